/* src/h264fua_pkg.sv */
// Shared types, codes and helpers of the H.264 FU-A depacketizer.
`default_nettype none

package h264fua_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_DROP   = 2'd1;
    localparam logic [1:0] MODE_SINGLE = 2'd2;
    localparam logic [1:0] MODE_FUA    = 2'd3;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ABORT    = 2'd2;
    localparam logic [1:0] KIND_STATUS   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ORDER     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN   = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_NO_START  = 3'd4;
    localparam logic [2:0] ST_MISMATCH  = 3'd5;

    localparam logic [4:0] TYPE_FUA     = 5'd28;
    localparam logic [4:0] TYPE_MAX_NAL = 5'd23;
    localparam logic [4:0] TYPE_IDR     = 5'd5;
    localparam logic [4:0] TYPE_SPS     = 5'd7;
    localparam logic [4:0] TYPE_PPS     = 5'd8;

    localparam int NUM_SLOTS = 8;

    localparam logic [2:0] SLOT_ABORT    = 3'd0;
    localparam logic [2:0] SLOT_ZERO_A   = 3'd1;
    localparam logic [2:0] SLOT_ZERO_B   = 3'd2;
    localparam logic [2:0] SLOT_ZERO_C   = 3'd3;
    localparam logic [2:0] SLOT_ONE      = 3'd4;
    localparam logic [2:0] SLOT_BYTE     = 3'd5;
    localparam logic [2:0] SLOT_COMPLETE = 3'd6;
    localparam logic [2:0] SLOT_STATUS   = 3'd7;

    localparam logic [7:0] MASK_START_CODE = 8'b0001_1110;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [4:0]           ab_type;
        logic [31:0]          ab_ts;
        logic [7:0]           nal_byte;
        logic [4:0]           nal_type;
        logic [31:0]          nal_ts;
        logic [31:0]          st_ts;
        logic [2:0]           st_code;
        logic [15:0]          st_lost;
    } t_cmd;

    function automatic logic key_of(input logic [4:0] t);
        return (t == TYPE_IDR) || (t == TYPE_SPS) || (t == TYPE_PPS);
    endfunction

endpackage

`default_nettype wire

/* src/h264fua_in_if.sv */
// Input channel carrying one RTP payload byte per item.
`default_nettype none

interface h264fua_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] sequence_number;
    logic [31:0] rtp_timestamp;

    modport source (
        output valid, data_byte, first_byte, last_byte, sequence_number, rtp_timestamp,
        input  ready
    );
    modport sink (
        input  valid, data_byte, first_byte, last_byte, sequence_number, rtp_timestamp,
        output ready
    );
endinterface

`default_nettype wire

/* src/h264fua_out_if.sv */
// Output channel carrying one Annex-B result item.
`default_nettype none

interface h264fua_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  nal_byte;
    logic [4:0]  nal_type;
    logic        keyframe;
    logic [31:0] nal_timestamp;
    logic [2:0]  packet_status;
    logic [15:0] lost_packets;

    modport source (
        output valid, kind, nal_byte, nal_type, keyframe, nal_timestamp, packet_status,
               lost_packets,
        input  ready
    );
    modport sink (
        input  valid, kind, nal_byte, nal_type, keyframe, nal_timestamp, packet_status,
               lost_packets,
        output ready
    );
endinterface

`default_nettype wire

/* src/h264fua_front.sv */
// Front end: sequence check, packet classification and command generation.
`default_nettype none

module h264fua_front
    import h264fua_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    h264fua_in_if.sink  i_in,
    input  wire logic   i_push_ready,
    output logic        o_push_valid,
    output t_cmd        o_push_cmd
);

    logic        r_seen, n_seen;
    logic [15:0] r_last_seq, n_last_seq;
    logic        r_frag_open, n_frag_open;
    logic [31:0] r_frag_time, n_frag_time;
    logic [31:0] r_pkt_time, n_pkt_time;
    logic [1:0]  r_mode, n_mode;
    logic [1:0]  r_pos, n_pos;
    logic [2:0]  r_ind, n_ind;
    logic        r_end, n_end;
    logic [4:0]  r_cur_type, n_cur_type;
    logic [2:0]  r_status, n_status;
    logic [15:0] r_gap, n_gap;

    t_cmd        cmd;
    logic        accept;

    assign i_in.ready   = i_push_ready;
    assign accept       = i_in.valid && i_push_ready;
    assign o_push_valid = accept && (cmd.mask != '0);
    assign o_push_cmd   = cmd;

    always_comb begin
        logic [15:0] expect_seq;
        logic [4:0]  t;
        logic [7:0]  d;
        n_seen      = r_seen;
        n_last_seq  = r_last_seq;
        n_frag_open = r_frag_open;
        n_frag_time = r_frag_time;
        n_pkt_time  = r_pkt_time;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_ind       = r_ind;
        n_end       = r_end;
        n_cur_type  = r_cur_type;
        n_status    = r_status;
        n_gap       = r_gap;
        cmd         = '0;
        d           = i_in.data_byte;
        t           = d[4:0];
        expect_seq  = r_last_seq + 16'd1;

        if (i_in.first_byte) begin
            if (r_mode == MODE_SINGLE) begin
                cmd.mask[SLOT_ABORT] = 1'b1;
                cmd.ab_type          = r_cur_type;
                cmd.ab_ts            = r_pkt_time;
            end
            n_mode     = MODE_IDLE;
            n_pos      = 2'd0;
            n_end      = 1'b0;
            n_pkt_time = i_in.rtp_timestamp;
            n_gap      = 16'd0;
            n_status   = ST_OK;
            if (r_seen && (i_in.sequence_number != expect_seq)) begin
                if (i_in.sequence_number > expect_seq) begin
                    n_gap = i_in.sequence_number - expect_seq;
                    if (r_frag_open) begin
                        cmd.mask[SLOT_ABORT] = 1'b1;
                        cmd.ab_type          = r_cur_type;
                        cmd.ab_ts            = r_frag_time;
                        n_frag_open          = 1'b0;
                    end
                end else begin
                    n_status = ST_ORDER;
                    n_mode   = MODE_DROP;
                end
            end
            if (n_mode != MODE_DROP) begin
                n_last_seq = i_in.sequence_number;
                n_seen     = 1'b1;
                if ((t != 5'd0) && (t <= TYPE_MAX_NAL)) begin
                    if (n_frag_open) begin
                        cmd.mask[SLOT_ABORT] = 1'b1;
                        cmd.ab_type          = r_cur_type;
                        cmd.ab_ts            = r_frag_time;
                        n_frag_open          = 1'b0;
                    end
                    n_cur_type   = t;
                    cmd.mask     = cmd.mask | MASK_START_CODE;
                    cmd.mask[SLOT_BYTE] = 1'b1;
                    cmd.nal_byte = d;
                    cmd.nal_type = t;
                    cmd.nal_ts   = i_in.rtp_timestamp;
                    n_mode       = MODE_SINGLE;
                end else if (t == TYPE_FUA) begin
                    n_ind  = d[7:5];
                    n_mode = MODE_FUA;
                    n_pos  = 2'd1;
                    if (i_in.last_byte) begin
                        n_status = ST_SHORT;
                        n_mode   = MODE_DROP;
                    end
                end else begin
                    n_status = ST_UNKNOWN;
                    n_mode   = MODE_DROP;
                end
            end
        end else begin
            if (r_mode == MODE_SINGLE) begin
                cmd.mask[SLOT_BYTE] = 1'b1;
                cmd.nal_byte        = d;
                cmd.nal_type        = r_cur_type;
                cmd.nal_ts          = r_pkt_time;
            end else if (r_mode == MODE_FUA) begin
                if (r_pos == 2'd1) begin
                    n_pos = 2'd2;
                    if (d[7]) begin
                        if (r_frag_open) begin
                            cmd.mask[SLOT_ABORT] = 1'b1;
                            cmd.ab_type          = r_cur_type;
                            cmd.ab_ts            = r_frag_time;
                        end
                        n_frag_open  = 1'b1;
                        n_frag_time  = r_pkt_time;
                        n_cur_type   = t;
                        n_end        = 1'b0;
                        cmd.mask     = cmd.mask | MASK_START_CODE;
                        cmd.mask[SLOT_BYTE] = 1'b1;
                        cmd.nal_byte = {r_ind, t};
                        cmd.nal_type = t;
                        cmd.nal_ts   = r_pkt_time;
                    end else if (r_frag_open) begin
                        if (r_pkt_time != r_frag_time) begin
                            cmd.mask[SLOT_ABORT] = 1'b1;
                            cmd.ab_type          = r_cur_type;
                            cmd.ab_ts            = r_frag_time;
                            n_frag_open          = 1'b0;
                            n_status             = ST_MISMATCH;
                            n_mode               = MODE_DROP;
                        end else begin
                            n_end = d[6];
                        end
                    end else begin
                        n_status = ST_NO_START;
                        n_mode   = MODE_DROP;
                    end
                end else if (r_frag_open) begin
                    cmd.mask[SLOT_BYTE] = 1'b1;
                    cmd.nal_byte        = d;
                    cmd.nal_type        = r_cur_type;
                    cmd.nal_ts          = r_frag_time;
                end
            end
        end

        if (i_in.last_byte && (n_mode != MODE_IDLE)) begin
            if (n_mode == MODE_SINGLE) begin
                cmd.mask[SLOT_COMPLETE] = 1'b1;
                cmd.nal_type            = n_cur_type;
                cmd.nal_ts              = n_pkt_time;
            end else if ((n_mode == MODE_FUA) && n_end && n_frag_open) begin
                cmd.mask[SLOT_COMPLETE] = 1'b1;
                cmd.nal_type            = n_cur_type;
                cmd.nal_ts              = n_frag_time;
                n_frag_open             = 1'b0;
            end
            cmd.mask[SLOT_STATUS] = 1'b1;
            cmd.st_ts             = n_pkt_time;
            cmd.st_code           = n_status;
            cmd.st_lost           = n_gap;
            n_mode                = MODE_IDLE;
            n_pos                 = 2'd0;
            n_end                 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_last_seq  <= 16'd0;
            r_frag_open <= 1'b0;
            r_frag_time <= 32'd0;
            r_pkt_time  <= 32'd0;
            r_mode      <= MODE_IDLE;
            r_pos       <= 2'd0;
            r_ind       <= 3'd0;
            r_end       <= 1'b0;
            r_cur_type  <= 5'd0;
            r_status    <= ST_OK;
            r_gap       <= 16'd0;
        end else if (accept) begin
            r_seen      <= n_seen;
            r_last_seq  <= n_last_seq;
            r_frag_open <= n_frag_open;
            r_frag_time <= n_frag_time;
            r_pkt_time  <= n_pkt_time;
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_ind       <= n_ind;
            r_end       <= n_end;
            r_cur_type  <= n_cur_type;
            r_status    <= n_status;
            r_gap       <= n_gap;
        end
    end

endmodule

`default_nettype wire

/* src/h264fua_queue.sv */
// Command queue between the front end and the result sequencer.
`default_nettype none

module h264fua_queue
    import h264fua_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    input  t_cmd      i_push_cmd,
    output logic      o_push_ready,
    output logic      o_pop_valid,
    output t_cmd      o_pop_cmd,
    input  wire logic i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* src/h264fua_back.sv */
// Result sequencer: expands each command into result items on the output register.
`default_nettype none

module h264fua_back
    import h264fua_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_cmd_pop,
    h264fua_out_if.source o_out
);

    logic [NUM_SLOTS-1:0] r_done;
    logic [NUM_SLOTS-1:0] remaining, sel;
    logic [2:0]           sel_idx;
    logic                 last, fire;

    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic [4:0]  r_type;
    logic        r_key;
    logic [31:0] r_ts;
    logic [2:0]  r_status;
    logic [15:0] r_lost;

    logic [1:0]  n_kind;
    logic [7:0]  n_byte;
    logic [4:0]  n_type;
    logic [31:0] n_ts;
    logic [2:0]  n_status;
    logic [15:0] n_lost;

    assign remaining = i_cmd.mask & ~r_done;

    always_comb begin
        sel_idx = SLOT_STATUS;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (remaining[k]) begin
                sel_idx = 3'(k);
            end
        end
    end

    assign sel       = NUM_SLOTS'(1) << sel_idx;
    assign last      = ((remaining & ~sel) == '0);
    assign fire      = i_cmd_valid && (!r_out_valid || o_out.ready);
    assign o_cmd_pop = fire && last;

    always_comb begin
        n_kind   = KIND_BYTE;
        n_byte   = 8'h00;
        n_type   = i_cmd.nal_type;
        n_ts     = i_cmd.nal_ts;
        n_status = ST_OK;
        n_lost   = 16'd0;
        unique case (sel_idx)
            SLOT_ABORT: begin
                n_kind = KIND_ABORT;
                n_type = i_cmd.ab_type;
                n_ts   = i_cmd.ab_ts;
            end
            SLOT_ZERO_A, SLOT_ZERO_B, SLOT_ZERO_C: begin
                n_byte = 8'h00;
            end
            SLOT_ONE: begin
                n_byte = 8'h01;
            end
            SLOT_BYTE: begin
                n_byte = i_cmd.nal_byte;
            end
            SLOT_COMPLETE: begin
                n_kind = KIND_COMPLETE;
            end
            SLOT_STATUS: begin
                n_kind   = KIND_STATUS;
                n_type   = 5'd0;
                n_ts     = i_cmd.st_ts;
                n_status = i_cmd.st_code;
                n_lost   = i_cmd.st_lost;
            end
            default: begin
                n_kind = KIND_BYTE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_done <= last ? '0 : (r_done | sel);
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_kind   <= n_kind;
            r_byte   <= n_byte;
            r_type   <= n_type;
            r_key    <= (n_kind == KIND_STATUS) ? 1'b0 : key_of(n_type);
            r_ts     <= n_ts;
            r_status <= n_status;
            r_lost   <= n_lost;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.nal_byte      = r_byte;
    assign o_out.nal_type      = r_type;
    assign o_out.keyframe      = r_key;
    assign o_out.nal_timestamp = r_ts;
    assign o_out.packet_status = r_status;
    assign o_out.lost_packets  = r_lost;

endmodule

`default_nettype wire

/* src/h264_rtp_fua_depacketizer_unit.sv */
// Top level of the H.264 RTP single NAL and FU-A depacketizer.
//
//   Port     Direction  Item
//   i_in     sink       one RTP payload byte with first/last marks, sequence and timestamp
//   o_out    source     one Annex-B byte, NAL commit, NAL abort or packet status
//
// The front end accepts one item per cycle while the command queue has room.
// Each item yields zero to eight results, and the output register drains one per cycle
// while the output is ready; a NAL start can yield all eight.
// Reset is synchronous and active low and clears all control and packet state at once.
// Output stalls back up through the queue and only then hold off the input.
`default_nettype none

module h264_rtp_fua_depacketizer_unit
    import h264fua_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    h264fua_in_if.sink    i_in,
    h264fua_out_if.source o_out
);

    logic push_valid, push_ready, pop_valid, pop;
    t_cmd push_cmd, pop_cmd;

    h264fua_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd)
    );

    h264fua_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop        (pop)
    );

    h264fua_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_pop   (pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
